FILE: design/dkpf_pkg.sv
// Package of the diagonal Kalman pose filter: shared constants, command and
// status structs between controller and datapath, and a saturation helper.
// Depends on nothing.
package dkpf_pkg;

  localparam int unsigned AXES       = 3;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned VAR_W      = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned DIV_STEPS  = 17;
  localparam int unsigned ITEM_W     = 9 * WORD_W;

  localparam logic [VAR_W-1:0]  VAR_CAP     = 20'd655360;
  localparam logic [VAR_W-1:0]  VAR_RESET   = 20'd65536;
  localparam logic [GAIN_W-1:0] ONE_Q16     = 17'd65536;
  localparam logic [DT_W-1:0]   DT_RESET    = 16'd655;
  localparam logic [VAR_W-1:0]  QVAR_RESET  = 20'd655;
  localparam logic [VAR_W-1:0]  RVAR_RESET  = 20'd6554;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_VAR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_VAR  = 2'd2;

  // Operand selection of the shared multiplier.
  localparam logic [1:0] MUL_PRED = 2'd0;
  localparam logic [1:0] MUL_CORR = 2'd1;
  localparam logic [1:0] MUL_VAR  = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic [1:0] mul_op;
    logic [1:0] axis;
    logic       pred_acc;
    logic       corr_acc;
    logic       grow;
    logic       div_step;
    logic       div_first;
    logic       shrink_acc;
    logic       finish;
  } dkpf_cmd_t;

  typedef struct packed {
    logic out_free;
  } dkpf_status_t;

  // Clamp a 36-bit signed sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: design/dkpf_ctrl.sv
// Sequencer of the diagonal Kalman pose filter: steps the shared multiplier,
// the serial divider and the accumulate stages of the datapath.
// Depends on dkpf_pkg.
module dkpf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  dkpf_pkg::dkpf_status_t status,
  output dkpf_pkg::dkpf_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PMUL = 4'd1;
  localparam logic [3:0] ST_PACC = 4'd2;
  localparam logic [3:0] ST_GROW = 4'd3;
  localparam logic [3:0] ST_DIV  = 4'd4;
  localparam logic [3:0] ST_CMUL = 4'd5;
  localparam logic [3:0] ST_CACC = 4'd6;
  localparam logic [3:0] ST_VMUL = 4'd7;
  localparam logic [3:0] ST_VACC = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] axis, axis_next;
  logic [4:0] cnt, cnt_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.axis   = axis;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          axis_next   = 2'd0;
          state_next  = ST_PMUL;
        end
      end
      ST_PMUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = dkpf_pkg::MUL_PRED;
        state_next = ST_PACC;
      end
      ST_PACC: begin
        cmd.pred_acc = 1'b1;
        if (axis == 2'(dkpf_pkg::AXES - 1)) begin
          axis_next  = 2'd0;
          state_next = ST_GROW;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = ST_PMUL;
        end
      end
      ST_GROW: begin
        cmd.grow   = 1'b1;
        cnt_next   = 5'd0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt == 5'd0);
        cnt_next      = cnt + 5'd1;
        if (cnt == 5'(dkpf_pkg::DIV_STEPS - 1)) begin
          state_next = ST_CMUL;
        end
      end
      ST_CMUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = dkpf_pkg::MUL_CORR;
        state_next = ST_CACC;
      end
      ST_CACC: begin
        cmd.corr_acc = 1'b1;
        if (axis == 2'(dkpf_pkg::AXES - 1)) begin
          axis_next  = 2'd0;
          state_next = ST_VMUL;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = ST_CMUL;
        end
      end
      ST_VMUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = dkpf_pkg::MUL_VAR;
        state_next = ST_VACC;
      end
      ST_VACC: begin
        cmd.shrink_acc = 1'b1;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= 2'd0;
      cnt   <= 5'd0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      cnt   <= cnt_next;
    end
  end

endmodule

FILE: design/dkpf_datapath.sv
// Datapath of the diagonal Kalman pose filter: configuration registers,
// filter state, shared multiplier, serial divider and the output register.
// Depends on dkpf_pkg.
module dkpf_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [dkpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dkpf_pkg::VAR_W-1:0]   cfg_data,
  input  logic [dkpf_pkg::ITEM_W-1:0]  s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [dkpf_pkg::ITEM_W-1:0]  m_tdata,
  input  dkpf_pkg::dkpf_cmd_t           cmd,
  output dkpf_pkg::dkpf_status_t        status
);

  logic [dkpf_pkg::DT_W-1:0]  time_step;
  logic [dkpf_pkg::VAR_W-1:0] process_noise_var;
  logic [dkpf_pkg::VAR_W-1:0] meas_noise_var;

  logic signed [31:0] pos [dkpf_pkg::AXES];
  logic signed [31:0] vel [dkpf_pkg::AXES];
  logic signed [31:0] raw_pos [dkpf_pkg::AXES];
  logic [6*dkpf_pkg::WORD_W-1:0] raw_rest;
  logic [dkpf_pkg::VAR_W-1:0] var_cur;
  logic [dkpf_pkg::VAR_W-1:0] var_p;
  logic [dkpf_pkg::VAR_W:0]   denom;
  logic [dkpf_pkg::VAR_W+1:0] rem;
  logic [dkpf_pkg::GAIN_W-1:0] quot;
  logic signed [50:0] prod;

  logic [dkpf_pkg::GAIN_W-1:0] gain;
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [34:0] prod_shr;
  logic signed [35:0] acc_sum;
  logic [dkpf_pkg::VAR_W:0]   var_sum;
  logic [dkpf_pkg::VAR_W-1:0] var_grown;
  logic [dkpf_pkg::VAR_W+1:0] div_cand;
  logic                       div_ge;

  assign gain = (denom == '0) ? '0 : quot;

  // Operand selection for the one shared multiplier.
  always_comb begin
    unique case (cmd.mul_op)
      dkpf_pkg::MUL_PRED: begin
        mul_a = 33'(vel[cmd.axis]);
        mul_b = $signed({2'b00, time_step});
      end
      dkpf_pkg::MUL_CORR: begin
        mul_a = 33'(raw_pos[cmd.axis]) - 33'(pos[cmd.axis]);
        mul_b = $signed({1'b0, gain});
      end
      dkpf_pkg::MUL_VAR: begin
        mul_a = $signed({13'd0, var_p});
        mul_b = $signed({1'b0, dkpf_pkg::ONE_Q16 - gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The arithmetic shift is the floor division by 2^16.
  assign prod_shr = prod[50:16];
  assign acc_sum  = 36'(pos[cmd.axis]) + 36'(prod_shr);

  assign var_sum   = {1'b0, var_cur} + {1'b0, process_noise_var};
  assign var_grown = (var_sum > {1'b0, dkpf_pkg::VAR_CAP}) ? dkpf_pkg::VAR_CAP
                                                           : var_sum[dkpf_pkg::VAR_W-1:0];

  // Restoring division of var_p * 2^16 by denom; var_p never exceeds denom.
  assign div_cand = cmd.div_first ? {2'b00, var_p} : {rem[dkpf_pkg::VAR_W:0], 1'b0};
  assign div_ge   = (div_cand >= {1'b0, denom});

  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step         <= dkpf_pkg::DT_RESET;
      process_noise_var <= dkpf_pkg::QVAR_RESET;
      meas_noise_var    <= dkpf_pkg::RVAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dkpf_pkg::REG_TIME_STEP: time_step         <= cfg_data[dkpf_pkg::DT_W-1:0];
        dkpf_pkg::REG_PROC_VAR:  process_noise_var <= cfg_data;
        dkpf_pkg::REG_MEAS_VAR:  meas_noise_var    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dkpf_pkg::AXES; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
      var_cur  <= dkpf_pkg::VAR_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.pred_acc || cmd.corr_acc) begin
        pos[cmd.axis] <= dkpf_pkg::sat32(acc_sum);
      end
      if (cmd.shrink_acc) begin
        var_cur <= prod[35:16];
      end
      if (cmd.finish) begin
        for (int i = 0; i < dkpf_pkg::AXES; i++) begin
          vel[i] <= raw_rest[i*32 +: 32];
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int i = 0; i < dkpf_pkg::AXES; i++) begin
        raw_pos[i] <= s_tdata[i*32 +: 32];
      end
      raw_rest <= s_tdata[dkpf_pkg::ITEM_W-1:3*dkpf_pkg::WORD_W];
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.grow) begin
      var_p <= var_grown;
      denom <= {1'b0, var_grown} + {1'b0, meas_noise_var};
    end
    if (cmd.div_step) begin
      rem  <= div_ge ? (div_cand - {1'b0, denom}) : div_cand;
      quot <= {quot[dkpf_pkg::GAIN_W-2:0], div_ge};
    end
    if (cmd.finish) begin
      m_tdata <= {raw_rest, pos[2], pos[1], pos[0]};
    end
  end

endmodule

FILE: design/diagonal_kalman_pose_filter_unit.sv
// Top level of the diagonal Kalman pose filter.
// Depends on dkpf_pkg, dkpf_ctrl and dkpf_datapath.
//
// One item is one IMU sample of nine signed Q16.16 words. From acceptance
// until its result is loaded into the output register, each item passes in
// order through these steps: the three positions are predicted through the
// one shared multiplier, the shared variance is grown and capped, the serial
// divider forms the gain one quotient bit at a time, the positions are
// corrected, the variance is shrunk and the result is loaded. The serial
// divider and the shared multiplier take most of that time. A new item can
// be accepted in the cycle after the previous one has been loaded into the
// output register, and not before. This holds even while that result still
// waits to be taken; the block stalls only when a second result is ready
// before the first is taken.
// Velocities and angles pass through unchanged and the raw velocities are
// kept for the next prediction. Configuration writes take effect at once and
// are meant to be made only while no item is in progress.
module diagonal_kalman_pose_filter_unit (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration: 0 time_step, 1 process_noise_var, 2 meas_noise_var.
  input  logic                           cfg_we,
  input  logic [dkpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dkpf_pkg::VAR_W-1:0]     cfg_data,
  // s_tdata, lowest bit up: raw_pos_x, raw_pos_y, raw_pos_z, raw_vel_x,
  // raw_vel_y, raw_vel_z, raw_roll, raw_pitch, raw_yaw (32 bits each).
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dkpf_pkg::ITEM_W-1:0]    s_tdata,
  // m_tdata, lowest bit up: est_pos_x, est_pos_y, est_pos_z, est_vel_x,
  // est_vel_y, est_vel_z, est_roll, est_pitch, est_yaw (32 bits each).
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dkpf_pkg::ITEM_W-1:0]    m_tdata
);

  dkpf_pkg::dkpf_cmd_t    cmd;
  dkpf_pkg::dkpf_status_t status;

  dkpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dkpf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
